// ===== rtl/segment_intersection_core_defines.svh =====
// Assertion macros used by the segment intersection core.
`ifndef SEGMENT_INTERSECTION_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sic_pkg.sv =====
// Package with the result status codes of the segment intersection block.
package sic_pkg;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_CROSS    = 2'd1,
    ST_PARALLEL = 2'd2
  } status_e;

endpackage

// ===== rtl/sic_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, saturating signed result.
module sic_divider import sic_pkg::*; #(
  parameter int W  = 16,
  parameter int MW = 52,
  parameter int DW = 35
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [MW-1:0]       num_i,
  input  logic [DW-1:0]       den_i,
  input  logic                neg_i,
  output logic signed [W-1:0] quo_o
);

  logic [MW-1:0] r_q   [0:W];
  logic [W-1:0]  qb_q  [0:W];
  logic [DW-1:0] d_q   [0:W];
  logic          ovf_q [0:W];
  logic          neg_q [0:W];

  logic [MW-1:0] dtop;
  assign dtop = MW'(den_i) << W;

  // Stage 0: flag quotients that cannot fit in W bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num_i;
      qb_q[0]  <= '0;
      d_q[0]   <= den_i;
      ovf_q[0] <= (num_i >= dtop);
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [MW-1:0] dsh;
    logic          ge;
    assign dsh = MW'(d_q[k-1]) << (W - k);
    assign ge  = (r_q[k-1] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? (r_q[k-1] - dsh) : r_q[k-1];
        qb_q[k]  <= qb_q[k-1] | (ge ? (W'(1) << (W - k)) : W'(0));
        d_q[k]   <= d_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  logic [W-1:0] lim;
  logic [W-1:0] mag;
  assign lim = neg_q[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
  assign mag = (ovf_q[W] || (qb_q[W] > lim)) ? lim : qb_q[W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= neg_q[W] ? $signed(-mag) : $signed(mag);
    end
  end

endmodule

// ===== rtl/segment_intersection_core.sv =====
// Segment intersection core: test two segments and give their rounded crossing point.
//
// Input channel: valid_i / stall_o carry one beat of eight signed end point
// coordinates, segment A-B and segment C-D. Output channel: valid_o / stall_i
// carry one beat of status_o (none, cross, parallel) with cross_x_o and
// cross_y_o, which are zero unless status_o is cross. A beat moves on a rising
// edge with valid high and stall low.
// One result per input beat, in order. A beat can enter every cycle while the
// receiver does not stall; the pipeline is built from multiplier stages and a
// divider that resolves one quotient bit per stage.
// When the receiver stalls a waiting result, the whole pipeline holds and
// stall_o rises in the same cycle; nothing is dropped or repeated.
// Reset clears all stage valid bits; the pipeline is empty after reset.
`include "segment_intersection_core_defines.svh"
module segment_intersection_core import sic_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic signed [COORD_BITS-1:0] dx_i,
  input  logic signed [COORD_BITS-1:0] dy_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [1:0]                   status_o,
  output logic signed [COORD_BITS-1:0] cross_x_o,
  output logic signed [COORD_BITS-1:0] cross_y_o
);

  localparam int N   = COORD_BITS;
  localparam int D   = N + 1;
  localparam int PW  = 2 * N;
  localparam int CW  = 2 * N + 1;
  localparam int MPW = 2 * N + 2;
  localparam int SW  = 2 * N + 3;
  localparam int FW  = 3 * N + 2;
  localparam int NXW = 3 * N + 3;
  localparam int MW  = 3 * N + 4;
  localparam int LAT = N + 9;

  logic           adv;
  logic [LAT-1:0] vld_q;

  assign adv     = !(vld_q[LAT-1] && stall_i);
  assign stall_o = !adv;
  assign valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  // Stage 1: edge vectors and the cross terms of the line constants.
  logic signed [D-1:0]  a1_q, b1_q, a2_q, b2_q;
  logic signed [D-1:0]  e3x_q, e3y_q, e4x_q, e4y_q, f1x_q, f1y_q, f2x_q, f2y_q;
  logic signed [PW-1:0] p21_q, p12_q, p43_q, p34_q;

  function automatic logic signed [D-1:0] sub_d(logic signed [N-1:0] p,
                                                logic signed [N-1:0] q);
    return D'(p) - D'(q);
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q  <= sub_d(by_i, ay_i);
      b1_q  <= sub_d(ax_i, bx_i);
      a2_q  <= sub_d(dy_i, cy_i);
      b2_q  <= sub_d(cx_i, dx_i);
      e3x_q <= sub_d(cx_i, ax_i);
      e3y_q <= sub_d(cy_i, ay_i);
      e4x_q <= sub_d(dx_i, ax_i);
      e4y_q <= sub_d(dy_i, ay_i);
      f1x_q <= sub_d(ax_i, cx_i);
      f1y_q <= sub_d(ay_i, cy_i);
      f2x_q <= sub_d(bx_i, cx_i);
      f2y_q <= sub_d(by_i, cy_i);
      p21_q <= PW'(bx_i) * PW'(ay_i);
      p12_q <= PW'(ax_i) * PW'(by_i);
      p43_q <= PW'(dx_i) * PW'(cy_i);
      p34_q <= PW'(cx_i) * PW'(dy_i);
    end
  end

  // Stage 2: side-test products, determinant products, line constants.
  logic signed [MPW-1:0] sp3a_q, sp3b_q, sp4a_q, sp4b_q;
  logic signed [MPW-1:0] sp1a_q, sp1b_q, sp2a_q, sp2b_q;
  logic signed [MPW-1:0] dp1_q, dp2_q;
  logic signed [CW-1:0]  c1_q, c2_q;
  logic signed [D-1:0]   a1s_q, b1s_q, a2s_q, b2s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sp3a_q <= MPW'(a1_q) * MPW'(e3x_q);
      sp3b_q <= MPW'(b1_q) * MPW'(e3y_q);
      sp4a_q <= MPW'(a1_q) * MPW'(e4x_q);
      sp4b_q <= MPW'(b1_q) * MPW'(e4y_q);
      sp1a_q <= MPW'(a2_q) * MPW'(f1x_q);
      sp1b_q <= MPW'(b2_q) * MPW'(f1y_q);
      sp2a_q <= MPW'(a2_q) * MPW'(f2x_q);
      sp2b_q <= MPW'(b2_q) * MPW'(f2y_q);
      dp1_q  <= MPW'(a1_q) * MPW'(b2_q);
      dp2_q  <= MPW'(a2_q) * MPW'(b1_q);
      c1_q   <= CW'(p21_q) - CW'(p12_q);
      c2_q   <= CW'(p43_q) - CW'(p34_q);
      a1s_q  <= a1_q;
      b1s_q  <= b1_q;
      a2s_q  <= a2_q;
      b2s_q  <= b2_q;
    end
  end

  // Stage 3: side sums and status; numerator products split in two halves.
  logic signed [SW-1:0] s3, s4, s1, s2, den;
  logic                 same_ab, same_cd;
  status_e              st3;
  logic signed [D-1:0]  c1hi, c2hi, c1lo, c2lo;

  function automatic logic strict_same(logic signed [SW-1:0] p, logic signed [SW-1:0] q);
    return ((p > 0) && (q > 0)) || ((p < 0) && (q < 0));
  endfunction

  assign s3      = SW'(sp3a_q) + SW'(sp3b_q);
  assign s4      = SW'(sp4a_q) + SW'(sp4b_q);
  assign s1      = SW'(sp1a_q) + SW'(sp1b_q);
  assign s2      = SW'(sp2a_q) + SW'(sp2b_q);
  assign den     = SW'(dp1_q) - SW'(dp2_q);
  assign same_ab = strict_same(s3, s4);
  assign same_cd = strict_same(s1, s2);
  assign st3     = (same_ab || same_cd) ? ST_NONE : ((den == '0) ? ST_PARALLEL : ST_CROSS);
  assign c1hi    = $signed(c1_q[CW-1:N]);
  assign c2hi    = $signed(c2_q[CW-1:N]);
  assign c1lo    = $signed({1'b0, c1_q[N-1:0]});
  assign c2lo    = $signed({1'b0, c2_q[N-1:0]});

  logic signed [MPW-1:0] h_b1c2_q, l_b1c2_q, h_b2c1_q, l_b2c1_q;
  logic signed [MPW-1:0] h_a2c1_q, l_a2c1_q, h_a1c2_q, l_a1c2_q;
  logic signed [SW-1:0]  den3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_b1c2_q <= MPW'(b1s_q) * MPW'(c2hi);
      l_b1c2_q <= MPW'(b1s_q) * MPW'(c2lo);
      h_b2c1_q <= MPW'(b2s_q) * MPW'(c1hi);
      l_b2c1_q <= MPW'(b2s_q) * MPW'(c1lo);
      h_a2c1_q <= MPW'(a2s_q) * MPW'(c1hi);
      l_a2c1_q <= MPW'(a2s_q) * MPW'(c1lo);
      h_a1c2_q <= MPW'(a1s_q) * MPW'(c2hi);
      l_a1c2_q <= MPW'(a1s_q) * MPW'(c2lo);
      den3_q   <= den;
    end
  end

  // Stage 4: join the halves into full numerator products.
  function automatic logic signed [FW-1:0] join_pp(logic signed [MPW-1:0] hi,
                                                   logic signed [MPW-1:0] lo);
    logic signed [FW-1:0] h;
    h = FW'(hi);
    return (h <<< N) + FW'(lo);
  endfunction

  logic signed [FW-1:0] pb1c2_q, pb2c1_q, pa2c1_q, pa1c2_q;
  logic signed [SW-1:0] den4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pb1c2_q <= join_pp(h_b1c2_q, l_b1c2_q);
      pb2c1_q <= join_pp(h_b2c1_q, l_b2c1_q);
      pa2c1_q <= join_pp(h_a2c1_q, l_a2c1_q);
      pa1c2_q <= join_pp(h_a1c2_q, l_a1c2_q);
      den4_q  <= den3_q;
    end
  end

  // Stage 5: numerators and the determinant magnitude.
  logic signed [NXW-1:0] nx_q, ny_q;
  logic [SW-1:0]         dmag_q;
  logic                  dneg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q   <= NXW'(pb1c2_q) - NXW'(pa1c2_q - pa1c2_q + pb2c1_q);
      ny_q   <= NXW'(pa2c1_q) - NXW'(pa1c2_q);
      dmag_q <= den4_q[SW-1] ? $unsigned(-den4_q) : $unsigned(den4_q);
      dneg_q <= den4_q[SW-1];
    end
  end

  // Stage 6: numerator magnitudes with half the divisor added for rounding.
  logic signed [MW-1:0] nxe, nye;
  logic [MW-1:0]        off;
  assign nxe = MW'(nx_q);
  assign nye = MW'(ny_q);
  assign off = MW'(dmag_q >> 1);

  logic [MW-1:0] nxm_q, nym_q;
  logic [SW-1:0] dmag6_q;
  logic          qnx_q, qny_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nxm_q   <= (nxe[MW-1] ? $unsigned(-nxe) : $unsigned(nxe)) + off;
      nym_q   <= (nye[MW-1] ? $unsigned(-nye) : $unsigned(nye)) + off;
      dmag6_q <= dmag_q;
      qnx_q   <= nxe[MW-1] ^ dneg_q;
      qny_q   <= nye[MW-1] ^ dneg_q;
    end
  end

  logic signed [N-1:0] qx, qy;

  sic_divider #(.W(N), .MW(MW), .DW(SW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nxm_q),
    .den_i (dmag6_q),
    .neg_i (qnx_q),
    .quo_o (qx)
  );

  sic_divider #(.W(N), .MW(MW), .DW(SW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nym_q),
    .den_i (dmag6_q),
    .neg_i (qny_q),
    .quo_o (qy)
  );

  // Status travels alongside, from stage 3 to the output register.
  status_e st_q [2:LAT-2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[2] <= st3;
    end
  end

  for (genvar j = 3; j <= LAT - 2; j++) begin : g_st
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[j] <= st_q[j-1];
      end
    end
  end

  status_e             st_out_q;
  logic signed [N-1:0] cx_out_q, cy_out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_out_q <= st_q[LAT-2];
      cx_out_q <= (st_q[LAT-2] == ST_CROSS) ? qx : '0;
      cy_out_q <= (st_q[LAT-2] == ST_CROSS) ? qy : '0;
    end
  end

  assign status_o  = st_out_q;
  assign cross_x_o = cx_out_q;
  assign cross_y_o = cy_out_q;

  `SIC_ASSERT_IMP(a_zero_point, valid_o && (status_o != ST_CROSS), (cross_x_o == '0) && (cross_y_o == '0), "point not zero without crossing")
  `SIC_ASSERT_IMP(a_stall_src, stall_o, valid_o && stall_i, "stall raised without output backpressure")
  `SIC_ASSERT_NXT(a_freeze, !adv, $stable(vld_q), "pipeline valid bits moved while held")

endmodule
